// ===== src/touch_key_hold_chord_qualifier_top_macros.svh =====
// Assertion helpers for the block's modules; tkq_outq is the one that uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TOUCH_KEY_HOLD_CHORD_QUALIFIER_TOP_MACROS_SVH
`define TOUCH_KEY_HOLD_CHORD_QUALIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TKQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tkq assertion failed");
`define TKQ_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tkq forbidden condition seen");
`else
`define TKQ_ASSERT(lbl, prop)
`define TKQ_NEVER(lbl, expr)
`endif

`endif

// ===== src/tkq_pkg.sv =====
package tkq_pkg;

  localparam int READING_W  = 16;
  localparam int CFG_W      = 16;
  localparam int CMD_W      = 3;
  localparam int MAX_RES    = 5;
  localparam int NUM_PADS   = 5;
  localparam int NUM_SLOTS  = 7;
  localparam int CNT_W      = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [READING_W-1:0] reading_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;

  localparam cmd_t CMD_BACK   = 3'd0;
  localparam cmd_t CMD_ESC    = 3'd1;
  localparam cmd_t CMD_ENT    = 3'd2;
  localparam cmd_t CMD_ROT    = 3'd3;
  localparam cmd_t CMD_DIGIT1 = 3'd4;
  localparam cmd_t CMD_DIGIT2 = 3'd5;
  localparam cmd_t CMD_DIGIT3 = 3'd6;
  localparam cmd_t CMD_DIGIT4 = 3'd7;

  localparam logic [CFG_ADDR_W-3:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-3:0] REG_HOLD      = 2'd1;
  localparam logic [CFG_ADDR_W-3:0] REG_DEBOUNCE  = 2'd2;

  localparam cfg_word_t THRESHOLD_RST = 16'd25;
  localparam cfg_word_t HOLD_RST      = 16'd1000;
  localparam cfg_word_t DEBOUNCE_RST  = 16'd500;

  typedef struct packed {
    cfg_word_t touch_threshold;
    cfg_word_t hold_time_ms;
    cfg_word_t debounce_time_ms;
  } cfg_t;

  typedef struct packed {
    reading_t enter_reading;
    reading_t key_one_reading;
    reading_t key_two_reading;
    logic     rotate_event;
    logic     key_one_event;
    logic     key_two_event;
    logic     key_three_event;
    logic     key_four_event;
  } item_t;

  // Up to five commands caused by one tick, packed from slot 0 upward.
  typedef struct packed {
    cnt_t                   cnt;
    cmd_t [MAX_RES-1:0]     code;
  } bundle_t;

endpackage

// ===== src/tkq_ifs.sv =====
interface tkq_in_if import tkq_pkg::*; ();
  logic     valid;
  logic     ready;
  reading_t enter_reading;
  reading_t key_one_reading;
  reading_t key_two_reading;
  logic     rotate_event;
  logic     key_one_event;
  logic     key_two_event;
  logic     key_three_event;
  logic     key_four_event;

  modport source (
    output valid, enter_reading, key_one_reading, key_two_reading,
           rotate_event, key_one_event, key_two_event, key_three_event, key_four_event,
    input  ready
  );
  modport sink (
    input  valid, enter_reading, key_one_reading, key_two_reading,
           rotate_event, key_one_event, key_two_event, key_three_event, key_four_event,
    output ready
  );
endinterface

interface tkq_out_if import tkq_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t command_code;
  logic last_of_tick;

  modport source (output valid, command_code, last_of_tick, input ready);
  modport sink (input valid, command_code, last_of_tick, output ready);
endinterface

// ===== src/tkq_cfg.sv =====
module tkq_cfg import tkq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t                    cfg_r;
  logic [CFG_ADDR_W-3:0]   reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_threshold  <= THRESHOLD_RST;
      cfg_r.hold_time_ms     <= HOLD_RST;
      cfg_r.debounce_time_ms <= DEBOUNCE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg_r.touch_threshold  <= pwdata[CFG_W-1:0];
        REG_HOLD:      cfg_r.hold_time_ms     <= pwdata[CFG_W-1:0];
        REG_DEBOUNCE:  cfg_r.debounce_time_ms <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_THRESHOLD: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_r.touch_threshold};
      REG_HOLD:      prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_r.hold_time_ms};
      REG_DEBOUNCE:  prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_r.debounce_time_ms};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== src/tkq_core.sv =====
module tkq_core import tkq_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  input  cfg_t    cfg,
  input  logic    q_free,
  output logic    push,
  output bundle_t bundle
);

  typedef logic [TIME_BITS-1:0] time_t;

  function automatic logic past_limit(time_t now, time_t start, cfg_word_t lim);
    time_t d;
    d = now - start;
    return d > time_t'(lim);
  endfunction

  function automatic time_t later_of(time_t a, time_t b);
    return (a > b) ? a : b;
  endfunction

  logic  in_valid_r;
  item_t item_r;
  time_t tick_r, ent_start_r, k1_start_r, k2_start_r;
  logic  ent_held_r, k1_held_r, k2_held_r;
  logic  ent_done_r, esc_done_r, back_done_r;
  time_t last_fire_r [NUM_PADS];

  logic  eval_go;
  logic  ent_t, k1_t, k2_t;
  time_t ent_start_nxt, k1_start_nxt, k2_start_nxt;
  logic  back_done_mid, ent_done_mid, ent_done_two, esc_done_two, esc_done_three;
  logic  fire_back, fire_esc, fire_ent;
  logic  back_done_nxt, esc_done_nxt, ent_done_nxt;
  logic [NUM_PADS-1:0]  pad_req, pad_ok, pad_fired;
  logic [NUM_SLOTS-1:0] slot_want, slot_fired;
  cmd_t  slot_code [NUM_SLOTS];
  cnt_t  cnt;
  cmd_t [MAX_RES-1:0] code;

  assign eval_go  = in_valid_r & q_free;
  assign in_ready = ~in_valid_r | q_free;

  assign ent_t = item_r.enter_reading   < cfg.touch_threshold;
  assign k1_t  = item_r.key_one_reading < cfg.touch_threshold;
  assign k2_t  = item_r.key_two_reading < cfg.touch_threshold;

  // Hold and chord tracking in the order key two, back, enter, key one, escape/enter.
  always_comb begin
    k2_start_nxt  = (k2_t && !k2_held_r) ? tick_r : k2_start_r;
    back_done_mid = k2_t & k2_held_r & back_done_r;
    fire_back     = ent_held_r & k2_t & ~back_done_mid &
                    past_limit(tick_r, later_of(ent_start_r, k2_start_nxt), cfg.hold_time_ms);
    back_done_nxt = back_done_mid | fire_back;
    ent_done_mid  = ent_done_r | fire_back;

    ent_start_nxt = (ent_t && !ent_held_r) ? tick_r : ent_start_r;
    ent_done_two  = ent_t & ent_held_r & ent_done_mid;
    esc_done_two  = (ent_t && !ent_held_r) ? 1'b0 : esc_done_r;

    k1_start_nxt   = (k1_t && !k1_held_r) ? tick_r : k1_start_r;
    esc_done_three = k1_t & k1_held_r & esc_done_two;

    fire_esc = 1'b0;
    fire_ent = 1'b0;
    if (ent_t && k1_t && !esc_done_three) begin
      fire_esc = past_limit(tick_r, later_of(ent_start_nxt, k1_start_nxt), cfg.hold_time_ms);
    end else if (ent_t && !k1_t && !ent_done_two) begin
      fire_ent = past_limit(tick_r, ent_start_nxt, cfg.hold_time_ms);
    end
    esc_done_nxt = esc_done_three | fire_esc;
    ent_done_nxt = ent_done_two | fire_esc | fire_ent;
  end

  // Digit pads are muted while enter is held after this tick's tracking.
  assign pad_req = {item_r.key_four_event & ~ent_t, item_r.key_three_event & ~ent_t,
                    item_r.key_two_event & ~ent_t, item_r.key_one_event & ~ent_t,
                    item_r.rotate_event};

  always_comb begin
    for (int i = 0; i < NUM_PADS; i++) begin
      pad_ok[i] = past_limit(tick_r, last_fire_r[i], cfg.debounce_time_ms);
    end
  end

  assign slot_want = {pad_req & pad_ok, fire_esc | fire_ent, fire_back};

  always_comb begin
    slot_code[0] = CMD_BACK;
    slot_code[1] = fire_esc ? CMD_ESC : CMD_ENT;
    slot_code[2] = CMD_ROT;
    slot_code[3] = CMD_DIGIT1;
    slot_code[4] = CMD_DIGIT2;
    slot_code[5] = CMD_DIGIT3;
    slot_code[6] = CMD_DIGIT4;
  end

  // Pack wanted commands in order; anything beyond the fifth is dropped.
  always_comb begin
    cnt        = '0;
    code       = '0;
    slot_fired = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_want[i] && (cnt < cnt_t'(MAX_RES))) begin
        code[cnt]     = slot_code[i];
        slot_fired[i] = 1'b1;
        cnt           = cnt_t'(cnt + 1'b1);
      end
    end
  end

  assign pad_fired   = slot_fired[NUM_SLOTS-1:2];
  assign bundle.cnt  = cnt;
  assign bundle.code = code;
  assign push        = eval_go & (cnt != '0);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      tick_r      <= '0;
      ent_start_r <= '0;
      k1_start_r  <= '0;
      k2_start_r  <= '0;
      ent_held_r  <= 1'b0;
      k1_held_r   <= 1'b0;
      k2_held_r   <= 1'b0;
      ent_done_r  <= 1'b0;
      esc_done_r  <= 1'b0;
      back_done_r <= 1'b0;
      for (int i = 0; i < NUM_PADS; i++) begin
        last_fire_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (eval_go) begin
        tick_r      <= tick_r + 1'b1;
        ent_start_r <= ent_start_nxt;
        k1_start_r  <= k1_start_nxt;
        k2_start_r  <= k2_start_nxt;
        ent_held_r  <= ent_t;
        k1_held_r   <= k1_t;
        k2_held_r   <= k2_t;
        ent_done_r  <= ent_done_nxt;
        esc_done_r  <= esc_done_nxt;
        back_done_r <= back_done_nxt;
        for (int i = 0; i < NUM_PADS; i++) begin
          if (pad_fired[i]) begin
            last_fire_r[i] <= tick_r;
          end
        end
      end
    end
  end

endmodule

// ===== src/tkq_outq.sv =====
`include "touch_key_hold_chord_qualifier_top_macros.svh"

module tkq_outq import tkq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t bundle,
  output logic    q_free,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    out_code,
  output logic    out_last
);

  bundle_t bundle_r;
  cnt_t    idx_r;
  logic    valid_r;
  logic    out_fire;

  assign out_valid = valid_r;
  assign out_code  = bundle_r.code[idx_r];
  assign out_last  = (cnt_t'(idx_r + 1'b1) == bundle_r.cnt);
  assign out_fire  = valid_r & out_ready;
  assign q_free    = ~valid_r | (out_fire & out_last);

  always_ff @(posedge clk) begin
    if (push) begin
      bundle_r <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (push) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= cnt_t'(idx_r + 1'b1);
      end
    end
  end

  `TKQ_ASSERT(a_idx_in_range, valid_r |-> (bundle_r.cnt != '0) && (idx_r < bundle_r.cnt))
  `TKQ_ASSERT(a_mid_tick_keeps_valid, (out_fire && !out_last) |=> valid_r)
  `TKQ_ASSERT(a_drain_empties, (out_fire && out_last && !push) |=> !valid_r)
  `TKQ_NEVER(a_no_overwrite, push && valid_r && !(out_fire && out_last))

endmodule

// ===== src/touch_key_hold_chord_qualifier_top.sv =====
// Channel   Dir   Payload                                         Handshake
// in_ch     in    three 16-bit readings, five event flags         valid/ready
// out_ch    out   command_code (3 bits), last_of_tick             valid/ready
// cfg_*     in    APB registers: threshold, hold time, debounce   psel/penable/pready
//
// A tick is held in an input register and evaluated into a bundle register of up
// to five commands. While out_ch is ready, commands leave one per cycle and a
// new tick can be taken every cycle while each tick yields at most one command.
// A tick with several commands holds the next tick in the input register until
// its last command is taken. Reset is synchronous and clears all tracking state.
module touch_key_hold_chord_qualifier_top import tkq_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tkq_in_if.sink                in_ch,
  tkq_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  item_t   item;
  bundle_t bundle;
  logic    push;
  logic    q_free;

  assign item.enter_reading   = in_ch.enter_reading;
  assign item.key_one_reading = in_ch.key_one_reading;
  assign item.key_two_reading = in_ch.key_two_reading;
  assign item.rotate_event    = in_ch.rotate_event;
  assign item.key_one_event   = in_ch.key_one_event;
  assign item.key_two_event   = in_ch.key_two_event;
  assign item.key_three_event = in_ch.key_three_event;
  assign item.key_four_event  = in_ch.key_four_event;

  tkq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tkq_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (item),
    .cfg      (cfg),
    .q_free   (q_free),
    .push     (push),
    .bundle   (bundle)
  );

  tkq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bundle    (bundle),
    .q_free    (q_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_code  (out_ch.command_code),
    .out_last  (out_ch.last_of_tick)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tkq_pkg::*;

  localparam int TIME_BITS       = 32;
  localparam int PREDICTED       = -1;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int RANDOM_PHASES   = 7;
  localparam int PHASE_TICKS     = 21;
  localparam int MAX_REPORTS     = 10;

  typedef logic [TIME_BITS-1:0]             tick_ms_t;
  typedef logic [CFG_ADDR_W-3:0]            reg_idx_t;
  typedef logic [0:MAX_RES-1][CMD_W-1:0]    cmd_list_t;

  typedef struct packed {
    cmd_t code;
    logic last;
  } command_t;

  typedef struct {
    bit        is_cfg;
    reg_idx_t  reg_idx;
    cfg_word_t value;
    item_t     tick;
    int        n_known;
    cmd_list_t known;
  } step_t;

  localparam cmd_list_t NO_CMDS = '0;
  localparam cmd_t PAD_CMD [NUM_PADS] = '{CMD_ROT, CMD_DIGIT1, CMD_DIGIT2, CMD_DIGIT3,
                                          CMD_DIGIT4};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tkq_in_if  in_ch ();
  tkq_out_if out_ch ();

  touch_key_hold_chord_qualifier_top #(.TIME_BITS(TIME_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pad tracking state, mirrored from the block's behavior.
  cfg_t     settings;
  tick_ms_t ms_now;
  tick_ms_t enter_since, key1_since, key2_since;
  bit       enter_on, key1_on, key2_on;
  bit       enter_fired, escape_fired, back_fired;
  tick_ms_t pad_fired_at [NUM_PADS];

  command_t expected_cmds [$];
  step_t    script [$];
  bit       code_seen [8];

  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int ticks_sent = 0;
  int commands_checked = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  function automatic tick_ms_t since(input tick_ms_t now, input tick_ms_t start);
    return now - start;
  endfunction

  // Advances the pad state by one tick and lists the commands it causes.
  function automatic int qualify_tick(input item_t t, output cmd_list_t cmds);
    tick_ms_t now, start, hold;
    logic [NUM_PADS-1:0] pad_ev;
    bit ent_t, k1_t, k2_t;
    int n;
    now = ms_now;
    hold = tick_ms_t'(settings.hold_time_ms);
    ent_t = t.enter_reading < settings.touch_threshold;
    k1_t = t.key_one_reading < settings.touch_threshold;
    k2_t = t.key_two_reading < settings.touch_threshold;
    pad_ev = {t.key_four_event, t.key_three_event, t.key_two_event, t.key_one_event,
              t.rotate_event};
    cmds = NO_CMDS;
    n = 0;

    if (k2_t && !key2_on) begin
      key2_on = 1'b1;
      key2_since = now;
      back_fired = 1'b0;
    end
    if (!k2_t) begin
      key2_on = 1'b0;
      back_fired = 1'b0;
    end
    // The back chord looks at enter as it stood before this tick.
    if (enter_on && key2_on && !back_fired) begin
      start = (enter_since > key2_since) ? enter_since : key2_since;
      if (since(now, start) > hold) begin
        cmds[n] = CMD_BACK;
        n++;
        back_fired = 1'b1;
        enter_fired = 1'b1;
      end
    end

    if (ent_t && !enter_on) begin
      enter_on = 1'b1;
      enter_since = now;
      enter_fired = 1'b0;
      escape_fired = 1'b0;
    end
    if (!ent_t) begin
      enter_on = 1'b0;
      enter_fired = 1'b0;
    end

    if (k1_t && !key1_on) begin
      key1_on = 1'b1;
      key1_since = now;
      escape_fired = 1'b0;
    end
    if (!k1_t) begin
      key1_on = 1'b0;
      escape_fired = 1'b0;
    end

    if (enter_on && key1_on && !escape_fired) begin
      start = (enter_since > key1_since) ? enter_since : key1_since;
      if (since(now, start) > hold) begin
        cmds[n] = CMD_ESC;
        n++;
        escape_fired = 1'b1;
        enter_fired = 1'b1;
      end
    end else if (enter_on && !key1_on && !enter_fired) begin
      if (since(now, enter_since) > hold) begin
        cmds[n] = CMD_ENT;
        n++;
        enter_fired = 1'b1;
      end
    end

    // A pad that would overflow the tick's command list keeps its old fire time.
    for (int p = 0; p < NUM_PADS; p++) begin
      if (pad_ev[p] && (p == 0 || !enter_on) && n < MAX_RES &&
          since(now, pad_fired_at[p]) > tick_ms_t'(settings.debounce_time_ms)) begin
        cmds[n] = PAD_CMD[p];
        n++;
        pad_fired_at[p] = now;
      end
    end

    ms_now = now + tick_ms_t'(1);
    return n;
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  task automatic send_tick(input item_t t, input int n_known, input cmd_list_t known);
    cmd_list_t cmds;
    int n;
    while (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.enter_reading   <= t.enter_reading;
    in_ch.key_one_reading <= t.key_one_reading;
    in_ch.key_two_reading <= t.key_two_reading;
    in_ch.rotate_event    <= t.rotate_event;
    in_ch.key_one_event   <= t.key_one_event;
    in_ch.key_two_event   <= t.key_two_event;
    in_ch.key_three_event <= t.key_three_event;
    in_ch.key_four_event  <= t.key_four_event;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    n = qualify_tick(t, cmds);
    if (n_known != PREDICTED) begin
      n = n_known;
      cmds = known;
    end
    for (int i = 0; i < n; i++) begin
      expected_cmds.push_back('{code: cmds[i], last: (i == n - 1)});
    end
  endtask

  // Waits until every expected command has left and any silent tick has drained.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read-back of the same register.
  task automatic cfg_access(input reg_idx_t idx, input cfg_word_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_THRESHOLD: settings.touch_threshold = value;
      REG_HOLD:      settings.hold_time_ms = value;
      REG_DEBOUNCE:  settings.debounce_time_ms = value;
      default: ;
    endcase
    cfg_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== APB_DATA_W'(value)) begin
      flag($sformatf("register %0d read back %0h, expected %0h", idx, cfg_prdata, value));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input cfg_word_t thr, input cfg_word_t hold, input cfg_word_t deb);
    settle();
    cfg_access(REG_THRESHOLD, thr);
    cfg_access(REG_HOLD, hold);
    cfg_access(REG_DEBOUNCE, deb);
  endtask

  // Readings sit on either side of the threshold, often right at the boundary.
  function automatic reading_t reading_for(input bit touched);
    int thr;
    thr = settings.touch_threshold;
    if (touched && thr > 0) begin
      if ($urandom_range(3) == 0) return reading_t'(thr - 1);
      return reading_t'($urandom_range(thr - 1, 0));
    end
    if ($urandom_range(3) == 0) return reading_t'(thr);
    return reading_t'($urandom_range(65535, thr));
  endfunction

  // Random gestures: enter holds, both chords with a staggered second press,
  // enter letting go under a held key two, bare event taps and raw noise.
  task automatic random_phase(input int n_ticks);
    item_t t;
    int left, g, dur, lag;
    bit e_t, a_t, b_t, burst;
    left = n_ticks;
    while (left > 0) begin
      g = $urandom_range(9, 0);
      dur = (settings.hold_time_ms > 12) ? 16
                                         : $urandom_range(int'(settings.hold_time_ms) + 4, 1);
      lag = $urandom_range(3, 0);
      for (int i = 0; i < dur && left > 0; i++) begin
        burst = (g == 7 && i == dur - 1);
        e_t = (g <= 7) && !burst;
        a_t = (g == 2 || g == 3 || g == 6) && i >= lag;
        b_t = (g >= 4 && g <= 7) && i >= lag;
        if ($urandom_range(99) < 4) e_t = !e_t;
        if ($urandom_range(99) < 4) a_t = !a_t;
        if ($urandom_range(99) < 4) b_t = !b_t;
        t.enter_reading   = reading_for(e_t);
        t.key_one_reading = reading_for(a_t);
        t.key_two_reading = reading_for(b_t);
        if (g == 9) begin
          t.enter_reading   = reading_t'($urandom);
          t.key_one_reading = reading_t'($urandom);
          t.key_two_reading = reading_t'($urandom);
        end
        t.rotate_event    = burst || ($urandom_range(99) < 30);
        t.key_one_event   = burst || ($urandom_range(99) < 30);
        t.key_two_event   = burst || ($urandom_range(99) < 30);
        t.key_three_event = burst || ($urandom_range(99) < 30);
        t.key_four_event  = burst || ($urandom_range(99) < 30);
        send_tick(t, PREDICTED, NO_CMDS);
        left--;
      end
    end
  endtask

  function automatic step_t row_cfg(input reg_idx_t idx, input cfg_word_t value);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.value = value;
    return s;
  endfunction

  // Events are given as {rotate, digit one, digit two, digit three, digit four}.
  function automatic step_t row_tick(input reading_t ent, input reading_t k1, input reading_t k2,
                                     input logic [4:0] ev, input int n_known,
                                     input cmd_list_t known);
    step_t s;
    s = '{default: '0};
    s.tick.enter_reading   = ent;
    s.tick.key_one_reading = k1;
    s.tick.key_two_reading = k2;
    s.tick.rotate_event    = ev[4];
    s.tick.key_one_event   = ev[3];
    s.tick.key_two_event   = ev[2];
    s.tick.key_three_event = ev[1];
    s.tick.key_four_event  = ev[0];
    s.n_known = n_known;
    s.known = known;
    return s;
  endfunction

  task automatic check_command();
    command_t want;
    code_seen[out_ch.command_code] = 1'b1;
    if (expected_cmds.size() == 0) begin
      flag($sformatf("command %0d arrived with nothing expected", out_ch.command_code));
      return;
    end
    want = expected_cmds.pop_front();
    commands_checked++;
    if (out_ch.command_code !== want.code) begin
      flag($sformatf("command_code expected %0d, got %0d", want.code, out_ch.command_code));
    end
    if (out_ch.last_of_tick !== want.last) begin
      flag($sformatf("last_of_tick expected %0b, got %0b (code %0d)",
                     want.last, out_ch.last_of_tick, want.code));
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_command();
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int kinds;
    int directed;
    cfg_word_t thr, hold, deb;
    in_ch.valid <= 1'b0;
    in_ch.enter_reading <= '1;
    in_ch.key_one_reading <= '1;
    in_ch.key_two_reading <= '1;
    in_ch.rotate_event <= 1'b0;
    in_ch.key_one_event <= 1'b0;
    in_ch.key_two_event <= 1'b0;
    in_ch.key_three_event <= 1'b0;
    in_ch.key_four_event <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;

    settings = '{THRESHOLD_RST, HOLD_RST, DEBOUNCE_RST};
    ms_now = '0;
    enter_since = '0;
    key1_since = '0;
    key2_since = '0;
    {enter_on, key1_on, key2_on, enter_fired, escape_fired, back_fired} = '0;
    foreach (pad_fired_at[p]) pad_fired_at[p] = '0;

    script = '{
      // Reset settings: nothing can fire this early.
      row_tick(16'h0000, 16'h0000, 16'h0000, 5'b11111, 0, NO_CMDS),
      row_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111, 0, NO_CMDS),
      row_tick(16'd24, 16'd24, 16'd24, 5'b00000, 0, NO_CMDS),
      row_tick(16'd25, 16'd25, 16'd25, 5'b00000, 0, NO_CMDS),
      row_cfg(REG_THRESHOLD, 16'h8000),
      row_cfg(REG_HOLD, 16'd0),
      row_cfg(REG_DEBOUNCE, 16'd0),
      // Zero debounce, nothing touched: every event pad fires.
      row_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111, 5,
               {CMD_ROT, CMD_DIGIT1, CMD_DIGIT2, CMD_DIGIT3, CMD_DIGIT4}),
      row_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111, PREDICTED, NO_CMDS),
      // Enter held: digits are ignored, then enter alone, escape, back.
      row_tick(16'h7FFF, 16'hFFFF, 16'hFFFF, 5'b11111, PREDICTED, NO_CMDS),
      row_tick(16'h0000, 16'hFFFF, 16'hFFFF, 5'b00000, PREDICTED, NO_CMDS),
      row_tick(16'h0000, 16'h7FFF, 16'hFFFF, 5'b00000, PREDICTED, NO_CMDS),
      row_tick(16'h0000, 16'h7FFF, 16'hFFFF, 5'b00000, PREDICTED, NO_CMDS),
      row_tick(16'h0000, 16'hFFFF, 16'h0000, 5'b00000, PREDICTED, NO_CMDS),
      row_tick(16'h0000, 16'hFFFF, 16'h0000, 5'b00000, PREDICTED, NO_CMDS),
      row_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b00000, PREDICTED, NO_CMDS),
      // Back fires as enter lets go, so digits pile up past five commands.
      row_tick(16'h0000, 16'hFFFF, 16'h0000, 5'b00000, PREDICTED, NO_CMDS),
      row_tick(16'hFFFF, 16'hFFFF, 16'h0000, 5'b11111, PREDICTED, NO_CMDS),
      row_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b00001, PREDICTED, NO_CMDS),
      row_cfg(REG_THRESHOLD, 16'hFFFF),
      row_cfg(REG_HOLD, 16'hFFFF),
      row_cfg(REG_DEBOUNCE, 16'hFFFF),
      row_tick(16'hFFFE, 16'hFFFE, 16'hFFFE, 5'b11111, 0, NO_CMDS),
      row_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111, 0, NO_CMDS),
      row_cfg(REG_THRESHOLD, 16'd0),
      row_tick(16'h0000, 16'h0000, 16'h0000, 5'b11111, 0, NO_CMDS),
      row_cfg(REG_THRESHOLD, 16'd1000),
      row_cfg(REG_HOLD, 16'd3),
      row_cfg(REG_DEBOUNCE, 16'd2),
      // Enter held just under the threshold until the hold time is exceeded.
      row_tick(16'd999, 16'd1000, 16'd1000, 5'b10000, PREDICTED, NO_CMDS),
      row_tick(16'd999, 16'd1000, 16'd1000, 5'b10000, PREDICTED, NO_CMDS),
      row_tick(16'd999, 16'd1000, 16'd1000, 5'b10000, PREDICTED, NO_CMDS),
      row_tick(16'd999, 16'd1000, 16'd1000, 5'b10000, PREDICTED, NO_CMDS),
      row_tick(16'd999, 16'd1000, 16'd1000, 5'b10000, PREDICTED, NO_CMDS)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        cfg_access(script[i].reg_idx, script[i].value);
      end else begin
        send_tick(script[i].tick, script[i].n_known, script[i].known);
      end
    end
    directed = ticks_sent;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(1) == 0) thr = cfg_word_t'($urandom_range(65535, 1));
      else thr = cfg_word_t'($urandom_range(300, 1));
      hold = cfg_word_t'($urandom_range(6, 0));
      deb = cfg_word_t'($urandom_range(6, 0));
      if (ph == 1) begin
        hold = '0;
        deb = '0;
      end
      set_config(thr, hold, deb);
      calm = (ph == 2);
      // The result side stalls for a long stretch while ticks keep coming.
      if (ph == 4) hold_off_req = 1'b1;
      random_phase(PHASE_TICKS);
    end
    calm = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    kinds = 0;
    foreach (code_seen[c]) kinds += code_seen[c];
    $display("Run covered %0d ticks (%0d directed), %0d commands checked, %0d of 8 codes seen.",
             ticks_sent, directed, commands_checked, kinds);
    $display("%0d register writes with read-back, one long output hold-off, %0d mismatches.",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
